// ===== src/sbb_pkg.sv =====
// ----------------------------------------------------------------------------
// sbb_pkg
// Shared constants, types and arithmetic helpers of the separable 3x3 box blur.
// ----------------------------------------------------------------------------
package sbb_pkg;

	localparam int MAX_WIDTH   = 2048;
	localparam int MAX_HEIGHT  = 2048;

	localparam int CH_W        = 8;
	localparam int CFG_W       = 12;
	localparam int CFG_IDX_W   = 1;

	localparam int STORE_DEPTH = 2 * MAX_WIDTH;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);
	localparam int W_W         = $clog2(MAX_WIDTH + 1);
	localparam int H_W         = $clog2(MAX_HEIGHT + 1);
	localparam int POS_W       = $clog2(MAX_WIDTH * MAX_HEIGHT + MAX_WIDTH + 1);
	localparam int MUL_W       = W_W + H_W + 1;

	localparam int DIV3_MUL    = 683;
	localparam int DIV3_SHIFT  = 11;
	localparam int SUM_W       = CH_W + 2;
	localparam int PROD_W      = SUM_W + DIV3_SHIFT + 1;

	localparam logic [CFG_W-1:0] FRAME_WIDTH_RST  = CFG_W'(800);
	localparam logic [CFG_W-1:0] FRAME_HEIGHT_RST = CFG_W'(600);

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic [CH_W-1:0] r;
		logic [CH_W-1:0] g;
		logic [CH_W-1:0] b;
	} pix_t;

	localparam int PIX_W = $bits(pix_t);

	typedef logic [ADDR_W-1:0] addr_t;

	typedef struct packed {
		pix_t  cur;
		pix_t  prev1;
		pix_t  prev2;
		logic  have_h;
		logic  emit;
		logic  last;
		logic  gate_a;
		addr_t waddr;
		addr_t raddr_a;
		addr_t raddr_b;
	} iss_t;

	typedef struct packed {
		logic  en;
		addr_t addr;
		pix_t  data;
	} wr_t;

	function automatic logic [CH_W-1:0] div3(input logic [SUM_W-1:0] s);
		logic [PROD_W-1:0] prod;
		prod = PROD_W'(s) * PROD_W'(DIV3_MUL);
		return prod[DIV3_SHIFT +: CH_W];
	endfunction

	function automatic pix_t tri_avg(input pix_t a, input pix_t b, input pix_t c);
		pix_t res;
		res.r = div3(SUM_W'(a.r) + SUM_W'(b.r) + SUM_W'(c.r));
		res.g = div3(SUM_W'(a.g) + SUM_W'(b.g) + SUM_W'(c.g));
		res.b = div3(SUM_W'(a.b) + SUM_W'(b.b) + SUM_W'(c.b));
		return res;
	endfunction

	function automatic logic [W_W-1:0] clamp_w(input logic [CFG_W-1:0] v);
		logic [W_W-1:0] res;
		if (v == '0) begin
			res = W_W'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			res = W_W'(MAX_WIDTH);
		end else begin
			res = W_W'(v);
		end
		return res;
	endfunction

	function automatic logic [H_W-1:0] clamp_h(input logic [CFG_W-1:0] v);
		logic [H_W-1:0] res;
		if (v == '0) begin
			res = H_W'(1);
		end else if (int'(v) > MAX_HEIGHT) begin
			res = H_W'(MAX_HEIGHT);
		end else begin
			res = H_W'(v);
		end
		return res;
	endfunction

endpackage

// ===== src/sbb_if.sv =====
// ----------------------------------------------------------------------------
// sbb_if
// Valid/ready channels of the box blur: pixel input, result output, config.
// ----------------------------------------------------------------------------
interface sbb_in_if import sbb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic            mode;
	logic [CH_W-1:0] red_in;
	logic [CH_W-1:0] green_in;
	logic [CH_W-1:0] blue_in;

	modport source (output valid, mode, red_in, green_in, blue_in, input ready);
	modport sink   (input valid, mode, red_in, green_in, blue_in, output ready);
endinterface

interface sbb_out_if import sbb_pkg::*; ();
	logic            valid;
	logic            ready;
	logic [CH_W-1:0] red_out;
	logic [CH_W-1:0] green_out;
	logic [CH_W-1:0] blue_out;
	logic            last_pixel;

	modport source (output valid, red_out, green_out, blue_out, last_pixel, input ready);
	modport sink   (input valid, red_out, green_out, blue_out, last_pixel, output ready);
endinterface

interface sbb_cfg_if import sbb_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [CFG_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface

// ===== src/sbb_ram.sv =====
// ----------------------------------------------------------------------------
// sbb_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module sbb_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem[raddr_a];
			rdata_b <= mem[raddr_b];
		end
	end

endmodule

// ===== src/sbb_ctrl.sv =====
// ----------------------------------------------------------------------------
// sbb_ctrl
// Frame sequencing: config registers, frame size latch, position counter,
// pixel window, and the per-word issue decisions and store addresses.
// ----------------------------------------------------------------------------
module sbb_ctrl import sbb_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	sbb_cfg_if.sink       cfg,
	input  logic          accept,
	input  logic          mode,
	input  pix_t          pix,
	output logic          proceed,
	output iss_t          iss
);

	logic [CFG_W-1:0] fw_q;
	logic [CFG_W-1:0] fh_q;
	logic [W_W-1:0]   cw_q;
	logic [POS_W-1:0] n_q;
	logic [POS_W-1:0] end_q;
	logic [POS_W-1:0] pos_q;
	pix_t             win0_q;
	pix_t             win1_q;

	logic             first;
	logic [W_W-1:0]   w_new;
	logic [H_W-1:0]   h_new;
	logic [W_W-1:0]   w;
	logic [MUL_W-1:0] n_full;
	logic [MUL_W-1:0] end_full;
	logic             in_frame;
	logic [POS_W-1:0] w_ext;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fw_q <= FRAME_WIDTH_RST;
			fh_q <= FRAME_HEIGHT_RST;
		end else if (cfg.valid) begin
			unique case (cfg_reg_t'(cfg.index))
				REG_FRAME_WIDTH:  fw_q <= cfg.data;
				REG_FRAME_HEIGHT: fh_q <= cfg.data;
				default: ;
			endcase
		end
	end

	always_comb begin
		first    = (pos_q == '0);
		w_new    = clamp_w(fw_q);
		h_new    = clamp_h(fh_q);
		w        = first ? w_new : cw_q;
		w_ext    = POS_W'(w);
		n_full   = MUL_W'(w_new) * MUL_W'(h_new);
		end_full = n_full + MUL_W'(w_new);
		in_frame = first || (pos_q < n_q);
		proceed  = accept && !(in_frame && mode);

		iss.cur     = in_frame ? pix : '0;
		iss.prev1   = first ? '0 : win0_q;
		iss.prev2   = (pos_q > POS_W'(1)) ? win1_q : '0;
		iss.have_h  = !first && (pos_q <= n_q);
		iss.emit    = pos_q > w_ext;
		iss.last    = !first && (pos_q == end_q);
		iss.gate_a  = pos_q > (w_ext << 1);
		iss.waddr   = ADDR_W'(pos_q) - ADDR_W'(1);
		iss.raddr_b = ADDR_W'(pos_q) - ADDR_W'(w) - ADDR_W'(1);
		iss.raddr_a = ADDR_W'(pos_q) - ADDR_W'(w_ext << 1) - ADDR_W'(1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cw_q   <= W_W'(1);
			n_q    <= POS_W'(1);
			end_q  <= POS_W'(2);
			win0_q <= '0;
			win1_q <= '0;
		end else if (proceed) begin
			if (first) begin
				cw_q  <= w_new;
				n_q   <= n_full[POS_W-1:0];
				end_q <= end_full[POS_W-1:0];
			end
			pos_q  <= (iss.emit && iss.last) ? '0 : pos_q + POS_W'(1);
			win1_q <= win0_q;
			win0_q <= iss.cur;
		end
	end

endmodule

// ===== src/sbb_dpath.sv =====
// ----------------------------------------------------------------------------
// sbb_dpath
// Filter pipeline: horizontal average and row store write, vertical
// average, result register.
// ----------------------------------------------------------------------------
module sbb_dpath import sbb_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    proceed,
	input  iss_t    iss,
	input  pix_t    rdata_a,
	input  pix_t    rdata_b,
	input  logic    out_ready,
	output logic    s1_free,
	output wr_t     wr,
	output logic    out_valid,
	output pix_t    out_pix,
	output logic    out_last
);

	logic  s1_valid_q;
	pix_t  cur_s1;
	pix_t  prev1_s1;
	pix_t  prev2_s1;
	logic  have_h_s1;
	logic  emit_s1;
	logic  last_s1;
	logic  gate_a_s1;
	addr_t waddr_s1;
	logic  byp_a_s1;
	logic  byp_b_s1;
	pix_t  byp_s1;

	logic  s2_valid_q;
	pix_t  a_s2;
	pix_t  b_s2;
	pix_t  c_s2;
	logic  last_s2;

	logic  out_valid_q;
	pix_t  out_pix_q;
	logic  out_last_q;

	pix_t  h_s1;
	logic  out_free;
	logic  s2_free;
	logic  s2_adv;
	logic  s1_adv;
	logic  s2_load;

	always_comb begin
		h_s1     = tri_avg(prev2_s1, prev1_s1, cur_s1);
		out_free = !out_valid_q || out_ready;
		s2_adv   = s2_valid_q && out_free;
		s2_free  = !s2_valid_q || out_free;
		s1_adv   = s1_valid_q && (!emit_s1 || s2_free);
		s1_free  = !s1_valid_q || s1_adv;
		s2_load  = s1_adv && emit_s1;
		wr.en    = s1_adv && have_h_s1;
		wr.addr  = waddr_s1;
		wr.data  = h_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q  <= 1'b0;
			s2_valid_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (proceed) begin
				s1_valid_q <= 1'b1;
			end else if (s1_adv) begin
				s1_valid_q <= 1'b0;
			end
			if (s2_load) begin
				s2_valid_q <= 1'b1;
			end else if (s2_adv) begin
				s2_valid_q <= 1'b0;
			end
			if (s2_adv) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// bypass a same-cycle store write to a location the new word reads
	always_ff @(posedge clk) begin
		if (proceed) begin
			cur_s1    <= iss.cur;
			prev1_s1  <= iss.prev1;
			prev2_s1  <= iss.prev2;
			have_h_s1 <= iss.have_h;
			emit_s1   <= iss.emit;
			last_s1   <= iss.last;
			gate_a_s1 <= iss.gate_a;
			waddr_s1  <= iss.waddr;
			byp_a_s1  <= wr.en && (wr.addr == iss.raddr_a);
			byp_b_s1  <= wr.en && (wr.addr == iss.raddr_b);
			byp_s1    <= h_s1;
		end
		if (s2_load) begin
			a_s2    <= gate_a_s1 ? (byp_a_s1 ? byp_s1 : rdata_a) : '0;
			b_s2    <= byp_b_s1 ? byp_s1 : rdata_b;
			c_s2    <= have_h_s1 ? h_s1 : '0;
			last_s2 <= last_s1;
		end
		if (s2_adv) begin
			out_pix_q  <= tri_avg(a_s2, b_s2, c_s2);
			out_last_q <= last_s2;
		end
	end

	assign out_valid = out_valid_q;
	assign out_pix   = out_pix_q;
	assign out_last  = out_last_q;

endmodule

// ===== src/separable_box_blur_3x3_core.sv =====
// ----------------------------------------------------------------------------
// separable_box_blur_3x3_core
// Separable 3x3 box blur over a raster RGB888 stream with a two-row store.
//
//   channel  dir  payload                                      word
//   pix_in   in   mode, red_in, green_in, blue_in              one pixel or flush
//   pix_out  out  red_out, green_out, blue_out, last_pixel     one blurred pixel
//   cfg      in   index (frame_width, frame_height), data      one register write
//
// One word is accepted per cycle while the output does not stall. The row store
// is a 1W2R RAM with registered read, so throughput is one word per clock then.
// Reset clears control state only; the row store needs no clearing pass. A
// stalled output holds the pipeline once its bubbles are filled.
// ----------------------------------------------------------------------------
module separable_box_blur_3x3_core import sbb_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	sbb_in_if.sink   pix_in,
	sbb_out_if.source pix_out,
	sbb_cfg_if.sink  cfg
);

	logic  accept;
	logic  proceed;
	logic  s1_free;
	iss_t  iss;
	wr_t   wr;
	pix_t  in_pix;
	pix_t  rdata_a;
	pix_t  rdata_b;
	pix_t  out_pix;
	logic  out_valid;
	logic  out_last;

	assign pix_in.ready = s1_free;
	assign accept       = pix_in.valid && s1_free;
	assign in_pix.r     = pix_in.red_in;
	assign in_pix.g     = pix_in.green_in;
	assign in_pix.b     = pix_in.blue_in;

	sbb_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.accept  (accept),
		.mode    (pix_in.mode),
		.pix     (in_pix),
		.proceed (proceed),
		.iss     (iss)
	);

	sbb_ram #(
		.WIDTH (PIX_W),
		.DEPTH (STORE_DEPTH)
	) u_row_store (
		.clk     (clk),
		.we      (wr.en),
		.waddr   (wr.addr),
		.wdata   (wr.data),
		.re      (proceed),
		.raddr_a (iss.raddr_a),
		.raddr_b (iss.raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	sbb_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.proceed   (proceed),
		.iss       (iss),
		.rdata_a   (rdata_a),
		.rdata_b   (rdata_b),
		.out_ready (pix_out.ready),
		.s1_free   (s1_free),
		.wr        (wr),
		.out_valid (out_valid),
		.out_pix   (out_pix),
		.out_last  (out_last)
	);

	assign pix_out.valid      = out_valid;
	assign pix_out.red_out    = out_pix.r;
	assign pix_out.green_out  = out_pix.g;
	assign pix_out.blue_out   = out_pix.b;
	assign pix_out.last_pixel = out_last;

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && iss.emit && iss.last |=> !(proceed && iss.emit))
		else $error("word after frame end still emits");

	a_upper_row_emits: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && iss.gate_a |-> iss.emit)
		else $error("upper row read without emission");

	a_last_emits: assert property (@(posedge clk) disable iff (!arst_n)
		proceed && iss.last |-> iss.emit)
		else $error("last pixel flagged on non-emitting word");

	a_proceed_accepted: assert property (@(posedge clk) disable iff (!arst_n)
		proceed |-> pix_in.valid && pix_in.ready)
		else $error("pipeline loaded without accepted word");

endmodule
